### rtl/core/vagg_pkg.sv
// shared types and constants of the vector arrow glyph generator
package vagg_pkg;

    // field and register widths
    localparam int COMP_W     = 16;
    localparam int MAG_W      = 16;
    localparam int SIDE_W     = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_W      = 24;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GLYPH_COUNT  = 2'd2;

    // register reset values
    localparam logic [SIDE_W-1:0] PLANE_WIDTH_RST  = 13'd64;
    localparam logic [SIDE_W-1:0] PLANE_HEIGHT_RST = 13'd64;
    localparam logic [SIDE_W-1:0] GLYPH_COUNT_RST  = 13'd32;

    // arithmetic widths
    localparam int MSS_W      = 32;
    localparam int K_W        = 30;
    localparam int MUL_A_W    = 30;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_W      = 48;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int SQ_IN_W    = 48;
    localparam int SQ_W       = 24;
    localparam int SQ_REM_W   = 26;
    localparam int SQ_CNT_W   = $clog2(SQ_W + 1);
    localparam int SCALED_W   = 26;
    localparam int COORD_W    = 36;

    // longest arrow component magnitude in Q.8
    localparam logic [SCALED_W-2:0] SCALE_LIMIT = 25'd16777216;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    // square root request and response
    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] value;
    } sq_req_t;

    typedef struct packed {
        logic            done;
        logic [SQ_W-1:0] root;
    } sq_rsp_t;

endpackage

### rtl/core/vagg_div.sv
// iterative restoring divider, one quotient bit per cycle
module vagg_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  vagg_pkg::div_req_t req,
    output vagg_pkg::div_rsp_t rsp
);

    logic [vagg_pkg::DIV_W-1:0]     quo_reg;
    logic [vagg_pkg::DIV_W-1:0]     rem_reg;
    logic [vagg_pkg::DIV_W-1:0]     den_reg;
    logic [vagg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [vagg_pkg::DIV_W:0]       rem_sh;
    logic [vagg_pkg::DIV_W:0]       diff;
    logic                           ge;

    // trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[vagg_pkg::DIV_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = !diff[vagg_pkg::DIV_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= vagg_pkg::DIV_CNT_W'(vagg_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vagg_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[vagg_pkg::DIV_W-1:0] : rem_sh[vagg_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[vagg_pkg::DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/core/vagg_sqrt.sv
// iterative integer square root, one root bit per cycle
module vagg_sqrt
(
    input  logic              clk,
    input  logic              rst_n,
    input  vagg_pkg::sq_req_t req,
    output vagg_pkg::sq_rsp_t rsp
);

    logic [vagg_pkg::SQ_IN_W-1:0]  val_reg;
    logic [vagg_pkg::SQ_REM_W-1:0] rem_reg;
    logic [vagg_pkg::SQ_W-1:0]     root_reg;
    logic [vagg_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [vagg_pkg::SQ_REM_W+1:0] rem_sh;
    logic [vagg_pkg::SQ_REM_W+1:0] trial;
    logic [vagg_pkg::SQ_REM_W+2:0] diff;
    logic                          ge;

    // bring down two bits and try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, val_reg[vagg_pkg::SQ_IN_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = {1'b0, rem_sh} - {1'b0, trial};
        ge     = !diff[vagg_pkg::SQ_REM_W+2];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= vagg_pkg::SQ_CNT_W'(vagg_pkg::SQ_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vagg_pkg::SQ_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            val_reg  <= req.value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[vagg_pkg::SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[vagg_pkg::SQ_REM_W-1:0] : rem_sh[vagg_pkg::SQ_REM_W-1:0];
            root_reg <= {root_reg[vagg_pkg::SQ_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

### rtl/core/vector_arrow_glyph_generator_unit.sv
// top level: quiver arrow glyph generator with sequencer, shared multiplier and units
//
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata {v_value, u_value}, tuser {sample_valid, mode}
// m_axis    out  m_axis_tvalid/tready   tdata {y_end, x_end, y_start, x_start}, tlast glyph_last
// cfg       in   cfg_we                 cfg_addr register index, cfg_wdata value
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// scan item: the 48-step stride division, then the squared sum and the scan maximum
// skipped draw item: stride division only; kept draw item: stride divide, 24-step
// square root, two 48-step divisions, three result items through the output register
// m_axis stalls hold the sequencer in its emit step; reset is asynchronous, active low
module vector_arrow_glyph_generator_unit
#(
    parameter int MAX_SIDE = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // u_value[15:0], v_value[31:16]
    input  logic [1:0]  s_axis_tuser,   // mode[0], sample_valid[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_start, y_start, x_end, y_end, 24 bits each
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int SW    = vagg_pkg::SIDE_W;
    localparam int CW    = vagg_pkg::COORD_W;
    localparam int OW    = vagg_pkg::OUT_W;

    localparam logic [1:0] SEG_SHAFT = 2'd0;
    localparam logic [1:0] SEG_LEFT  = 2'd1;
    localparam logic [1:0] SEG_RIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STRIDE,
        ST_SUM_U,
        ST_SUM_V,
        ST_SCAN,
        ST_SQRT,
        ST_DEN,
        ST_NUM_U,
        ST_DIV_U,
        ST_DIV_V,
        ST_EMIT,
        ST_ADVANCE
    } state_t;

    state_t                           state_reg;
    logic [SW-1:0]                    plane_width_reg;
    logic [SW-1:0]                    plane_height_reg;
    logic [SW-1:0]                    glyph_count_reg;
    logic [vagg_pkg::MSS_W-1:0]       mss_reg;
    logic [POS_W-1:0]                 col_reg;
    logic [POS_W-1:0]                 row_reg;
    logic [SW-1:0]                    col_phase_reg;
    logic [SW-1:0]                    row_phase_reg;
    logic                             pass_reg;
    logic [SW-1:0]                    stride_reg;
    logic                             mode_reg;
    logic                             valid_reg;
    logic [vagg_pkg::MAG_W-1:0]       mu_reg;
    logic [vagg_pkg::MAG_W-1:0]       mv_reg;
    logic                             nu_reg;
    logic                             nv_reg;
    logic [vagg_pkg::MSS_W:0]         acc_reg;
    logic [vagg_pkg::SQ_W-1:0]        sq_reg;
    logic [vagg_pkg::DIV_W-1:0]       den_reg;
    logic signed [vagg_pkg::SCALED_W-1:0] a_reg;
    logic signed [vagg_pkg::SCALED_W-1:0] b_reg;
    logic [1:0]                       seg_reg;
    logic                             out_valid_reg;
    logic                             out_last_reg;
    logic [OW-1:0]                    out_xs_reg;
    logic [OW-1:0]                    out_ys_reg;
    logic [OW-1:0]                    out_xe_reg;
    logic [OW-1:0]                    out_ye_reg;
    vagg_pkg::div_req_t               div_req_reg;
    vagg_pkg::div_rsp_t               div_rsp;
    vagg_pkg::sq_req_t                sq_req_reg;
    vagg_pkg::sq_rsp_t                sq_rsp;

    logic [SW-1:0]                    w_eff;
    logic [SW-1:0]                    h_eff;
    logic [SW-1:0]                    cnt_eff;
    logic [SW-1:0]                    longest;
    logic [vagg_pkg::K_W-1:0]         k_val;
    logic [vagg_pkg::COMP_W-1:0]      u_raw;
    logic [vagg_pkg::COMP_W-1:0]      v_raw;
    logic [vagg_pkg::MAG_W-1:0]       u_mag;
    logic [vagg_pkg::MAG_W-1:0]       v_mag;
    logic                             in_accept;
    logic [vagg_pkg::MUL_A_W-1:0]     mul_a;
    logic [vagg_pkg::MUL_B_W-1:0]     mul_b;
    logic [vagg_pkg::PROD_W-1:0]      prod;
    logic                             draw_ok;
    logic [vagg_pkg::MSS_W-1:0]       scan_base;
    logic [vagg_pkg::MSS_W-1:0]       scan_sum;
    logic                             div_start;
    logic                             sq_start;
    logic                             round_up;
    logic [vagg_pkg::DIV_W:0]         q_round;
    logic [vagg_pkg::SCALED_W-2:0]    q_mag;
    logic                             scale_neg;
    logic signed [vagg_pkg::SCALED_W-1:0] scaled;
    logic signed [CW-1:0]             bx;
    logic signed [CW-1:0]             by;
    logic signed [CW-1:0]             ax;
    logic signed [CW-1:0]             ay;
    logic signed [CW-1:0]             tx;
    logic signed [CW-1:0]             ty;
    logic signed [CW-1:0]             lx;
    logic signed [CW-1:0]             ly;
    logic signed [CW-1:0]             rx;
    logic signed [CW-1:0]             ry;
    logic signed [CW-1:0]             seg_xs;
    logic signed [CW-1:0]             seg_ys;
    logic signed [CW-1:0]             seg_xe;
    logic signed [CW-1:0]             seg_ye;
    logic                             out_free;

    // saturate a coordinate to the output range
    function automatic logic [OW-1:0] sat_out(input logic signed [CW-1:0] v);
        logic [OW-1:0] r;
        if (v > $signed(CW'(8388607)))
            r = 24'h7FFFFF;
        else if (v < -$signed(CW'(8388608)))
            r = 24'h800000;
        else
            r = v[OW-1:0];
        return r;
    endfunction

    // effective plane geometry and scale constant
    always_comb
    begin
        if (plane_width_reg == '0)
            w_eff = SW'(1);
        else if (32'(plane_width_reg) > 32'(MAX_SIDE))
            w_eff = SW'(MAX_SIDE);
        else
            w_eff = plane_width_reg;
        if (plane_height_reg == '0)
            h_eff = SW'(1);
        else if (32'(plane_height_reg) > 32'(MAX_SIDE))
            h_eff = SW'(MAX_SIDE);
        else
            h_eff = plane_height_reg;
        cnt_eff = (glyph_count_reg == '0) ? SW'(1) : glyph_count_reg;
        longest = (w_eff > h_eff) ? w_eff : h_eff;
        // 81920 = 5 * 2^14
        k_val   = (vagg_pkg::K_W'(longest) << 16) + (vagg_pkg::K_W'(longest) << 14);
    end

    // component sign and magnitude
    always_comb
    begin
        u_raw     = s_axis_tdata[15:0];
        v_raw     = s_axis_tdata[31:16];
        u_mag     = u_raw[vagg_pkg::COMP_W-1] ? (-u_raw) : u_raw;
        v_mag     = v_raw[vagg_pkg::COMP_W-1] ? (-v_raw) : v_raw;
        in_accept = s_axis_tvalid && s_axis_tready;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SUM_U:
            begin
                mul_a = vagg_pkg::MUL_A_W'(mu_reg);
                mul_b = vagg_pkg::MUL_B_W'(mu_reg);
            end
            ST_SUM_V:
            begin
                mul_a = vagg_pkg::MUL_A_W'(mv_reg);
                mul_b = vagg_pkg::MUL_B_W'(mv_reg);
            end
            ST_DEN:
            begin
                mul_a = vagg_pkg::MUL_A_W'(cnt_eff);
                mul_b = sq_reg;
            end
            ST_NUM_U:
            begin
                mul_a = k_val;
                mul_b = vagg_pkg::MUL_B_W'(mu_reg);
            end
            ST_DIV_U:
            begin
                mul_a = k_val;
                mul_b = vagg_pkg::MUL_B_W'(mv_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = vagg_pkg::PROD_W'(mul_a) * vagg_pkg::PROD_W'(mul_b);
    end

    // scan maximum and draw decision
    always_comb
    begin
        draw_ok   = (col_phase_reg == '0) && (row_phase_reg == '0) && valid_reg
                    && (mss_reg != '0) && ((mu_reg != '0) || (mv_reg != '0));
        scan_base = ((col_reg == '0) && (row_reg == '0)) ? '0 : mss_reg;
        scan_sum  = acc_reg[vagg_pkg::MSS_W] ? '1 : acc_reg[vagg_pkg::MSS_W-1:0];
    end

    // start pulses of the divider and the square root unit
    always_comb
    begin
        div_start = ((state_reg == ST_IDLE) && in_accept)
                    || (state_reg == ST_NUM_U)
                    || ((state_reg == ST_DIV_U) && div_rsp.done);
        sq_start  = (state_reg == ST_STRIDE) && div_rsp.done && mode_reg && draw_ok;
    end

    // rounding and clamping of a scaled component
    always_comb
    begin
        round_up  = {div_rsp.rem, 1'b0} >= {1'b0, den_reg};
        q_round   = {1'b0, div_rsp.quo} + (vagg_pkg::DIV_W+1)'(round_up);
        q_mag     = (q_round > (vagg_pkg::DIV_W+1)'(vagg_pkg::SCALE_LIMIT))
                    ? vagg_pkg::SCALE_LIMIT : q_round[vagg_pkg::SCALED_W-2:0];
        scale_neg = (state_reg == ST_DIV_U) ? nu_reg : nv_reg;
        scaled    = scale_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // glyph geometry, barbs in eighths rounded half up
    always_comb
    begin
        bx = $signed(CW'({col_reg, 8'h80}));
        by = $signed(CW'({row_reg, 8'h80}));
        ax = CW'(a_reg);
        ay = CW'(b_reg);
        tx = bx + ax;
        ty = by + ay;
        lx = ((tx <<< 3) - (ax <<< 1) - ay + CW'(4)) >>> 3;
        ly = ((ty <<< 3) - (ay <<< 1) + ax + CW'(4)) >>> 3;
        rx = ((tx <<< 3) - (ax <<< 1) + ay + CW'(4)) >>> 3;
        ry = ((ty <<< 3) - (ay <<< 1) - ax + CW'(4)) >>> 3;
        case (seg_reg)
            SEG_SHAFT:
            begin
                seg_xs = bx;
                seg_ys = by;
                seg_xe = tx;
                seg_ye = ty;
            end
            SEG_LEFT:
            begin
                seg_xs = tx;
                seg_ys = ty;
                seg_xe = lx;
                seg_ye = ly;
            end
            default:
            begin
                seg_xs = tx;
                seg_ys = ty;
                seg_xe = rx;
                seg_ye = ry;
            end
        endcase
        out_free = !out_valid_reg || m_axis_tready;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= vagg_pkg::PLANE_WIDTH_RST;
            plane_height_reg <= vagg_pkg::PLANE_HEIGHT_RST;
            glyph_count_reg  <= vagg_pkg::GLYPH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                vagg_pkg::REG_PLANE_WIDTH:  plane_width_reg  <= cfg_wdata;
                vagg_pkg::REG_PLANE_HEIGHT: plane_height_reg <= cfg_wdata;
                vagg_pkg::REG_GLYPH_COUNT:  glyph_count_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, raster state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mss_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            pass_reg      <= 1'b0;
            stride_reg    <= SW'(1);
            seg_reg       <= SEG_SHAFT;
            out_valid_reg <= 1'b0;
            div_req_reg   <= '0;
            sq_req_reg    <= '0;
        end
        else
        begin
            div_req_reg.start <= div_start;
            sq_req_reg.start  <= sq_start;
            if ((state_reg == ST_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        mode_reg  <= s_axis_tuser[0];
                        valid_reg <= s_axis_tuser[1];
                        mu_reg    <= u_mag;
                        mv_reg    <= v_mag;
                        nu_reg    <= u_raw[vagg_pkg::COMP_W-1];
                        nv_reg    <= v_raw[vagg_pkg::COMP_W-1];
                        // a pass change restarts the raster walk
                        if (s_axis_tuser[0] != pass_reg)
                        begin
                            col_reg       <= '0;
                            row_reg       <= '0;
                            col_phase_reg <= '0;
                            row_phase_reg <= '0;
                        end
                        pass_reg          <= s_axis_tuser[0];
                        div_req_reg.num   <= vagg_pkg::DIV_W'(longest);
                        div_req_reg.den   <= vagg_pkg::DIV_W'(cnt_eff);
                        state_reg         <= ST_STRIDE;
                    end
                end
                ST_STRIDE:
                begin
                    if (div_rsp.done)
                    begin
                        stride_reg <= (div_rsp.quo == '0) ? SW'(1) : div_rsp.quo[SW-1:0];
                        if (!mode_reg)
                            state_reg <= ST_SUM_U;
                        else if (draw_ok)
                        begin
                            sq_req_reg.value <= {mss_reg, 16'h0000};
                            state_reg        <= ST_SQRT;
                        end
                        else
                            state_reg <= ST_ADVANCE;
                    end
                end
                ST_SUM_U:
                begin
                    acc_reg   <= prod[vagg_pkg::MSS_W:0];
                    state_reg <= ST_SUM_V;
                end
                ST_SUM_V:
                begin
                    acc_reg   <= acc_reg + prod[vagg_pkg::MSS_W:0];
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    mss_reg   <= (valid_reg && (scan_sum > scan_base)) ? scan_sum : scan_base;
                    state_reg <= ST_ADVANCE;
                end
                ST_SQRT:
                begin
                    if (sq_rsp.done)
                    begin
                        sq_reg    <= sq_rsp.root;
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN:
                begin
                    den_reg   <= prod[vagg_pkg::DIV_W-1:0];
                    state_reg <= ST_NUM_U;
                end
                ST_NUM_U:
                begin
                    div_req_reg.num   <= prod[vagg_pkg::DIV_W-1:0];
                    div_req_reg.den   <= den_reg;
                    state_reg         <= ST_DIV_U;
                end
                ST_DIV_U:
                begin
                    if (div_rsp.done)
                    begin
                        a_reg             <= scaled;
                        div_req_reg.num   <= prod[vagg_pkg::DIV_W-1:0];
                        div_req_reg.den   <= den_reg;
                        state_reg         <= ST_DIV_V;
                    end
                end
                ST_DIV_V:
                begin
                    if (div_rsp.done)
                    begin
                        b_reg     <= scaled;
                        seg_reg   <= SEG_SHAFT;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_last_reg  <= (seg_reg == SEG_RIGHT);
                        out_xs_reg    <= sat_out(seg_xs);
                        out_ys_reg    <= sat_out(seg_ys);
                        out_xe_reg    <= sat_out(seg_xe);
                        out_ye_reg    <= sat_out(seg_ye);
                        seg_reg       <= seg_reg + 2'd1;
                        if (seg_reg == SEG_RIGHT)
                            state_reg <= ST_ADVANCE;
                    end
                end
                ST_ADVANCE:
                begin
                    // step the raster position and stride phases
                    if (32'(col_reg) + 32'd1 >= 32'(w_eff))
                    begin
                        col_reg       <= '0;
                        col_phase_reg <= '0;
                        if (32'(row_reg) + 32'd1 >= 32'(h_eff))
                        begin
                            row_reg       <= '0;
                            row_phase_reg <= '0;
                        end
                        else
                        begin
                            row_reg       <= row_reg + 1'b1;
                            row_phase_reg <= (32'(row_phase_reg) + 32'd1 >= 32'(stride_reg))
                                             ? '0 : row_phase_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg       <= col_reg + 1'b1;
                        col_phase_reg <= (32'(col_phase_reg) + 32'd1 >= 32'(stride_reg))
                                         ? '0 : col_phase_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    vagg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    vagg_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req_reg),
        .rsp   (sq_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_ye_reg, out_xe_reg, out_ys_reg, out_xs_reg};

endmodule
